[hdl/fpsk_pkg.sv]
// ----------------------------------------------------------------------------
// fpsk_pkg
// Shared types, widths, register indexes and reset values for the frame pacer.
// ----------------------------------------------------------------------------
package fpsk_pkg;

  // Timestamp width and internal time width (timestamp times frame rate)
  localparam int TIMESTAMP_BITS = 48;
  localparam int RATE_BITS      = 8;
  localparam int TIME_BITS      = TIMESTAMP_BITS + RATE_BITS;
  localparam int TICK_BITS      = 32;
  localparam int BUDGET_BITS    = 8;
  localparam int OUT_BITS       = 32;

  // Shift-add multiply runs one multiplier bit per cycle
  localparam int MUL_STEPS    = RATE_BITS;
  localparam int MUL_CNT_BITS = $clog2(MUL_STEPS);

  // Divider retires one quotient bit per cycle
  localparam int DIV_CNT_BITS = $clog2(TIME_BITS);

  // Configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  typedef logic [TIMESTAMP_BITS-1:0] stamp_t;
  typedef logic [TIME_BITS-1:0]      time_t;
  typedef logic [RATE_BITS-1:0]      rate_t;
  typedef logic [TICK_BITS-1:0]      tick_t;
  typedef logic [BUDGET_BITS-1:0]    budget_t;
  typedef logic [OUT_BITS-1:0]       out_word_t;
  typedef logic [CFG_IDX_BITS-1:0]   cfg_idx_t;
  typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

  // Register indexes
  localparam cfg_idx_t REG_FRAMES_PER_SECOND = 2'd0;
  localparam cfg_idx_t REG_TICKS_PER_SECOND  = 2'd1;
  localparam cfg_idx_t REG_MAX_FRAME_SKIP    = 2'd2;

  // Register reset values
  localparam rate_t   FPS_RESET      = 8'd60;
  localparam tick_t   TPS_RESET      = 32'd1000000;
  localparam budget_t MAX_SKIP_RESET = 8'd4;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_NOW,
    ST_BUDGET,
    ST_ADVANCE,
    ST_MUL_SPAN,
    ST_LIMIT,
    ST_CHECK,
    ST_PULL,
    ST_GAP,
    ST_LOSS,
    ST_SLEEP,
    ST_DIVIDE,
    ST_HOLD
  } fsm_state_t;

endpackage

[hdl/fpsk_channels.sv]
// ----------------------------------------------------------------------------
// fpsk_channels
// Valid/ready channels of the frame pacer: frame events, results, config.
// ----------------------------------------------------------------------------

// Frame-begin event channel
interface fpsk_frame_if import fpsk_pkg::*;;
  logic   valid;
  logic   ready;
  stamp_t timestamp_ticks;
  logic   clear_time_lost;

  modport source (output valid, output timestamp_ticks, output clear_time_lost,
                  input ready);
  modport sink   (input valid, input timestamp_ticks, input clear_time_lost,
                  output ready);
endinterface

// Pacing result channel
interface fpsk_result_if import fpsk_pkg::*;;
  logic      valid;
  logic      ready;
  logic      skip_frame;
  out_word_t sleep_ticks;
  out_word_t time_lost_ticks;
  budget_t   skips_remaining;

  modport source (output valid, output skip_frame, output sleep_ticks,
                  output time_lost_ticks, output skips_remaining, input ready);
  modport sink   (input valid, input skip_frame, input sleep_ticks,
                  input time_lost_ticks, input skips_remaining, output ready);
endinterface

// Register write channel
interface fpsk_cfg_if import fpsk_pkg::*;;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/fpsk_div.sv]
// ----------------------------------------------------------------------------
// fpsk_div
// Restoring divider, internal time by frame rate, one quotient bit per cycle,
// quotient saturated to the 32-bit result width.
// ----------------------------------------------------------------------------
module fpsk_div import fpsk_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  time_t     dividend,
  input  rate_t     divisor,
  output logic      busy,
  output out_word_t quotient
);

  time_t                   quo;
  rate_t                   rem;
  rate_t                   dvs;
  logic [DIV_CNT_BITS-1:0] cnt;

  logic [RATE_BITS:0] trial;
  logic [RATE_BITS:0] trial_diff;
  logic               fits;

  // One restoring step: bring down the next dividend bit
  always_comb begin
    trial      = {rem, quo[TIME_BITS-1]};
    trial_diff = trial - {1'b0, dvs};
    fits       = trial >= {1'b0, dvs};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_BITS'(TIME_BITS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: quotient shifts in over the dividend
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[TIME_BITS-2:0], fits};
      rem <= fits ? trial_diff[RATE_BITS-1:0] : trial[RATE_BITS-1:0];
    end
  end

  // Saturate to the result width
  generate
    if (TIME_BITS > OUT_BITS) begin : g_sat
      assign quotient = (|quo[TIME_BITS-1:OUT_BITS]) ? '1 : quo[OUT_BITS-1:0];
    end else begin : g_wide
      assign quotient = out_word_t'(quo);
    end
  endgenerate

endmodule

[hdl/frame_pacer_with_skip_budget.sv]
// ----------------------------------------------------------------------------
// frame_pacer_with_skip_budget
// Fixed-timestep frame limiter with a frame-skip budget.
// ----------------------------------------------------------------------------
// Usage:
//   frame  : one request per frame begin, carrying the tick timestamp and a
//            flag that clears the lost-time total once this result is out.
//   result : one request per frame: skip flag, ticks to sleep, lost time in
//            ticks and the skip budget left.
//   cfg    : register writes (0 frame rate, 1 tick rate, 2 max frame skip),
//            always ready; write only while no frame is in flight.
// Sequencing: one frame at a time. Each frame runs the timestamp multiply;
//   later frames then run the budget, advance, span multiply, limit and check
//   steps, plus the pull, gap and loss steps when the deadline is pulled
//   forward. Every frame ends with the sleep step and the divide (two dividers
//   side by side); the multiplies are shift-add on the shared adder. The next
//   frame is taken the cycle after the result is staged. frame.ready is high
//   only while the sequencer is idle.
// Reset: registers return to 60 fps, 1000000 ticks/s, skip budget 4; the
//   next frame is treated as the first one.
// Stall: a result waits in the output register; the sequencer holds its
//   finished result and takes no frame until the receiver drains it.
// ----------------------------------------------------------------------------
module frame_pacer_with_skip_budget import fpsk_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  fpsk_frame_if.sink    frame,
  fpsk_result_if.source result,
  fpsk_cfg_if.sink      cfg
);

  fsm_state_t state;
  fsm_state_t state_next;

  // Configuration registers
  rate_t   fps;
  tick_t   tps;
  budget_t max_skip;

  // Pacing state
  time_t   deadline;
  time_t   current;
  time_t   lost;
  budget_t budget;
  logic    first;

  // Working registers
  time_t                   now;
  time_t                   span;
  time_t                   acc;
  time_t                   mcand;
  rate_t                   mplier;
  logic [MUL_CNT_BITS-1:0] cnt;
  logic                    clear_q;
  logic                    skip_q;

  // Shared adder
  time_t            alu_a;
  time_t            alu_b;
  logic             alu_sub;
  logic [TIME_BITS:0] alu_full;
  time_t            alu_sum;
  logic             alu_carry;

  logic      mul_last;
  logic      div_start;
  time_t     sleep_dividend;
  rate_t     divisor;
  logic      sleep_busy;
  logic      lost_busy;
  logic      div_busy;
  out_word_t sleep_quo;
  out_word_t lost_quo;
  logic      out_valid;
  logic      out_load;
  logic      frame_acc;

  assign frame_acc   = frame.valid && frame.ready;
  assign frame.ready = (state == ST_IDLE);
  assign cfg.ready   = 1'b1;
  assign mul_last    = (cnt == MUL_CNT_BITS'(MUL_STEPS - 1));
  assign div_busy    = sleep_busy || lost_busy;
  assign divisor     = (fps == '0) ? rate_t'(1) : fps;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fps      <= FPS_RESET;
      tps      <= TPS_RESET;
      max_skip <= MAX_SKIP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_FRAMES_PER_SECOND: fps      <= cfg.data[RATE_BITS-1:0];
        REG_TICKS_PER_SECOND:  tps      <= cfg.data[TICK_BITS-1:0];
        REG_MAX_FRAME_SKIP:    max_skip <= cfg.data[BUDGET_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (frame_acc) state_next = ST_MUL_NOW;
      ST_MUL_NOW:  if (mul_last) state_next = first ? ST_SLEEP : ST_BUDGET;
      ST_BUDGET:   state_next = ST_ADVANCE;
      ST_ADVANCE:  state_next = ST_MUL_SPAN;
      ST_MUL_SPAN: if (mul_last) state_next = ST_LIMIT;
      ST_LIMIT:    state_next = ST_CHECK;
      ST_CHECK:    state_next = alu_carry ? ST_SLEEP : ST_PULL;
      ST_PULL:     state_next = ST_GAP;
      ST_GAP:      state_next = ST_LOSS;
      ST_LOSS:     state_next = ST_SLEEP;
      ST_SLEEP:    state_next = ST_DIVIDE;
      ST_DIVIDE:   if (!div_busy) state_next = ST_HOLD;
      ST_HOLD:     if (!out_valid || result.ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Control outputs: adder operands, divider start, result load
  always_comb begin
    alu_a     = '0;
    alu_b     = '0;
    alu_sub   = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_MUL_NOW, ST_MUL_SPAN: begin
        alu_a = acc;
        alu_b = mplier[0] ? mcand : '0;
      end
      ST_BUDGET: begin
        alu_a   = deadline;
        alu_b   = current;
        alu_sub = 1'b1;
      end
      ST_ADVANCE: begin
        alu_a = deadline;
        alu_b = time_t'(tps);
      end
      ST_LIMIT: begin
        alu_a = deadline;
        alu_b = span;
      end
      ST_CHECK: begin
        alu_a   = acc;
        alu_b   = now;
        alu_sub = 1'b1;
      end
      ST_PULL: begin
        alu_a   = now;
        alu_b   = span;
        alu_sub = 1'b1;
      end
      ST_GAP: begin
        alu_a   = deadline;
        alu_b   = acc;
        alu_sub = 1'b1;
      end
      ST_LOSS: begin
        alu_a = lost;
        alu_b = acc;
      end
      ST_SLEEP: begin
        alu_a     = deadline;
        alu_b     = now;
        alu_sub   = 1'b1;
        div_start = 1'b1;
      end
      ST_HOLD: begin
        out_load = !out_valid || result.ready;
      end
      default: ;
    endcase
  end

  // Shared add/subtract; carry out is the no-borrow flag on subtracts
  always_comb begin
    alu_full  = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
              + (TIME_BITS + 1)'(alu_sub);
    alu_sum   = alu_full[TIME_BITS-1:0];
    alu_carry = alu_full[TIME_BITS];
  end

  // Sleep dividend: zero unless the deadline is ahead of now
  assign sleep_dividend = (alu_carry && (alu_sum != '0)) ? alu_sum : '0;

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pacing state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      deadline <= '0;
      current  <= '0;
      lost     <= '0;
      budget   <= MAX_SKIP_RESET;
      first    <= 1'b1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (frame_acc) begin
            mcand   <= time_t'(frame.timestamp_ticks);
            mplier  <= fps;
            acc     <= '0;
            cnt     <= '0;
            clear_q <= frame.clear_time_lost;
          end
        end
        ST_MUL_NOW, ST_MUL_SPAN: begin
          acc    <= alu_sum;
          mcand  <= {mcand[TIME_BITS-2:0], 1'b0};
          mplier <= mplier >> 1;
          cnt    <= cnt + 1'b1;
          if (mul_last) begin
            if (state == ST_MUL_NOW) begin
              now <= alu_sum;
              if (first) begin
                deadline <= alu_sum;
                first    <= 1'b0;
              end
            end else begin
              span <= alu_sum;
            end
          end
        end
        ST_BUDGET: begin
          // deadline earlier than the previous frame time: spend one skip
          if (!alu_carry) begin
            if (budget != '0) begin
              budget <= budget - 1'b1;
            end
          end else begin
            budget <= max_skip;
          end
        end
        ST_ADVANCE: begin
          deadline <= alu_sum;
          mcand    <= time_t'(tps);
          mplier   <= budget;
          acc      <= '0;
          cnt      <= '0;
        end
        ST_LIMIT: begin
          acc <= alu_sum;
        end
        ST_PULL: begin
          acc      <= deadline;
          deadline <= alu_sum;
        end
        ST_GAP: begin
          acc <= alu_sum;
        end
        ST_LOSS: begin
          lost <= alu_carry ? '1 : alu_sum;
        end
        ST_SLEEP: begin
          current <= now;
          skip_q  <= !alu_carry;
        end
        ST_HOLD: begin
          if (out_load && clear_q) begin
            lost <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Dividers for sleep time and lost time
  fpsk_div u_sleep_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sleep_dividend),
    .divisor  (divisor),
    .busy     (sleep_busy),
    .quotient (sleep_quo)
  );

  fpsk_div u_lost_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (lost),
    .divisor  (divisor),
    .busy     (lost_busy),
    .quotient (lost_quo)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.skip_frame      <= skip_q;
      result.sleep_ticks     <= sleep_quo;
      result.time_lost_ticks <= lost_quo;
      result.skips_remaining <= budget;
    end
  end

  assign result.valid = out_valid;

`ifndef NO_ASSERTIONS
  // An accepted frame starts the timestamp multiply
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    frame_acc |=> (state == ST_MUL_NOW))
    else $error("accepted frame did not start the sequencer");

  // Dividers are never restarted mid-divide
  a_div_start_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // Result is only staged once both divides are finished
  a_hold_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD) |-> !div_busy)
    else $error("result staged before divide finished");

  // A late frame never reports a sleep time
  a_skip_no_sleep: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.skip_frame && (result.sleep_ticks != '0)))
    else $error("skip flag with nonzero sleep time");
`endif

endmodule
